// ===== sv/mke_pkg.sv =====
// Shared types, constants and the Morse pattern table for the keying encoder.
// No dependencies; every other file imports this package.
package mke_pkg;

	localparam int CHAR_W          = 8;
	localparam int DOT_W           = 16;
	localparam int DASH_W          = 3;
	localparam int DUR_W           = 19;
	localparam int DOTS_W          = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 1;
	localparam int TABLE_SYMBOLS   = 5;
	localparam int LEN_W           = $clog2(TABLE_SYMBOLS + 1);
	localparam int POS_W           = 6;
	localparam int LETTER_COUNT    = 26;
	localparam int WORD_GAP_DOTS   = 6;
	localparam int LETTER_GAP_DOTS = 2;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int M_TDATA_W       = 24;

	localparam logic [DOT_W-1:0]  DOT_LENGTH_RST = 16'd100;
	localparam logic [DASH_W-1:0] DASH_DOTS_RST  = 3'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_DOT_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DASH_DOTS  = 1'b1;

	typedef enum logic {
		KIND_SPACE,
		KIND_CHAR
	} mke_kind_t;

	typedef struct packed {
		logic [LEN_W-1:0]         len;
		logic [TABLE_SYMBOLS-1:0] pat;   // bit j set: symbol j is a dash
	} mke_code_t;

	typedef struct packed {
		mke_kind_t kind;
		mke_code_t code;
	} mke_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mke_qstat_t;

	function automatic mke_code_t mke_code(input logic [POS_W-1:0] pos);
		mke_code_t c;
		case (pos)
			6'd0:    c = '{3'd2, 5'b00010};
			6'd1:    c = '{3'd4, 5'b00001};
			6'd2:    c = '{3'd4, 5'b00101};
			6'd3:    c = '{3'd3, 5'b00001};
			6'd4:    c = '{3'd1, 5'b00000};
			6'd5:    c = '{3'd4, 5'b00100};
			6'd6:    c = '{3'd3, 5'b00011};
			6'd7:    c = '{3'd4, 5'b00000};
			6'd8:    c = '{3'd2, 5'b00000};
			6'd9:    c = '{3'd4, 5'b01110};
			6'd10:   c = '{3'd3, 5'b00101};
			6'd11:   c = '{3'd4, 5'b00010};
			6'd12:   c = '{3'd2, 5'b00011};
			6'd13:   c = '{3'd2, 5'b00001};
			6'd14:   c = '{3'd3, 5'b00111};
			6'd15:   c = '{3'd4, 5'b00110};
			6'd16:   c = '{3'd4, 5'b01011};
			6'd17:   c = '{3'd3, 5'b00010};
			6'd18:   c = '{3'd3, 5'b00000};
			6'd19:   c = '{3'd1, 5'b00001};
			6'd20:   c = '{3'd3, 5'b00100};
			6'd21:   c = '{3'd4, 5'b01000};
			6'd22:   c = '{3'd3, 5'b00110};
			6'd23:   c = '{3'd4, 5'b01001};
			6'd24:   c = '{3'd4, 5'b01101};
			6'd25:   c = '{3'd4, 5'b00011};
			6'd26:   c = '{3'd5, 5'b11111};
			6'd27:   c = '{3'd5, 5'b11110};
			6'd28:   c = '{3'd5, 5'b11100};
			6'd29:   c = '{3'd5, 5'b11000};
			6'd30:   c = '{3'd5, 5'b10000};
			6'd31:   c = '{3'd5, 5'b00000};
			6'd32:   c = '{3'd5, 5'b00001};
			6'd33:   c = '{3'd5, 5'b00011};
			6'd34:   c = '{3'd5, 5'b00111};
			6'd35:   c = '{3'd5, 5'b01111};
			default: c = '{3'd0, 5'b00000};
		endcase
		return c;
	endfunction

endpackage

// ===== sv/mke_front.sv =====
// Front end: accepts characters, classifies them and looks up the Morse pattern.
// Depends on mke_pkg; feeds mke_queue.
module mke_front (
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [mke_pkg::CHAR_W-1:0] s_tdata,   // [7:0] character
	input  mke_pkg::mke_qstat_t       qstat,
	output logic                      push,
	output mke_pkg::mke_item_t        item
);
	import mke_pkg::*;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;

	logic             is_space;
	logic             is_letter;
	logic             is_digit;
	logic [CHAR_W-1:0] diff;
	logic [POS_W-1:0] pos;

	always_comb begin
		is_space  = (s_tdata == CHAR_SPACE);
		is_letter = s_tdata inside {[CHAR_A:CHAR_Z]};
		is_digit  = s_tdata inside {[CHAR_0:CHAR_9]};
		diff      = is_letter ? (s_tdata - CHAR_A) : (s_tdata - CHAR_0);
		pos       = is_letter ? diff[POS_W-1:0]
		                      : diff[POS_W-1:0] + POS_W'(LETTER_COUNT);
		item.kind = is_space ? KIND_SPACE : KIND_CHAR;
		item.code = mke_code(pos);
	end

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready && (is_space || is_letter || is_digit);

endmodule

// ===== sv/mke_queue.sv =====
// Short queue between front end and segment sequencer.
// Depends on mke_pkg.
module mke_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mke_pkg::mke_item_t  wr_item,
	input  logic                pop,
	output mke_pkg::mke_item_t  rd_item,
	output mke_pkg::mke_qstat_t qstat
);
	import mke_pkg::*;

	mke_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) |-> (qstat.full || qstat.empty))
		else $error("queue pointers disagree with count");

endmodule

// ===== sv/mke_back.sv =====
// Segment sequencer: walks the queued pattern; a key segment per unstalled cycle.
// Depends on mke_pkg; reads mke_queue head and drives the output register.
module mke_back #(
	parameter int MAX_SYMBOLS = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  mke_pkg::mke_item_t            head,
	output logic                          pop,
	input  logic [mke_pkg::DOT_W-1:0]     dot_length,
	input  logic [mke_pkg::DASH_W-1:0]    dash_dots,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mke_pkg::M_TDATA_W-1:0] m_tdata,   // [0] key_on, [19:1] duration
	output logic                          m_tlast
);
	import mke_pkg::*;

	localparam int LIM   = (MAX_SYMBOLS < TABLE_SYMBOLS) ? MAX_SYMBOLS : TABLE_SYMBOLS;
	localparam int SYM_W = $clog2(LIM + 1);

	logic [SYM_W-1:0]  sym_q;
	logic              phase_q;
	logic              m_tvalid_q;
	logic              key_on_q;
	logic [DUR_W-1:0]  duration_q;
	logic              last_q;

	logic              adv;
	logic [SYM_W-1:0]  eff_len;
	logic              seg_on;
	logic [DOTS_W-1:0] seg_dots;
	logic              seg_last;
	logic [DUR_W-1:0]  seg_dur;

	always_comb begin
		adv     = head_valid && (!m_tvalid_q || m_tready);
		eff_len = (head.code.len > LEN_W'(LIM)) ? SYM_W'(LIM) : SYM_W'(head.code.len);
		if (head.kind == KIND_SPACE) begin
			seg_on   = 1'b0;
			seg_dots = DOTS_W'(WORD_GAP_DOTS);
			seg_last = 1'b1;
		end else if (sym_q < eff_len) begin
			seg_on   = phase_q;
			seg_dots = (phase_q && head.code.pat[sym_q]) ? dash_dots : DOTS_W'(1);
			seg_last = 1'b0;
		end else begin
			seg_on   = 1'b0;
			seg_dots = DOTS_W'(LETTER_GAP_DOTS);
			seg_last = 1'b1;
		end
		seg_dur = DUR_W'(dot_length) * DUR_W'(seg_dots);
		pop     = adv && seg_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q      <= '0;
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= 1'b1;
				if (seg_last) begin
					sym_q   <= '0;
					phase_q <= 1'b0;
				end else if (phase_q) begin
					sym_q   <= sym_q + 1'b1;
					phase_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_on_q   <= seg_on;
			duration_q <= seg_dur;
			last_q     <= seg_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - DUR_W - 1)'(0), duration_q, key_on_q};
	assign m_tlast  = last_q;

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		sym_q <= SYM_W'(LIM))
		else $error("symbol counter out of range");

	a_phase_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (sym_q < SYM_W'(LIM)))
		else $error("key phase past the last symbol");

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (sym_q == '0) && !phase_q)
		else $error("sequencer not rewound after item end");

endmodule

// ===== sv/morse_keying_encoder.sv =====
// Top level of the Morse keying encoder: configuration registers and the
// front end, queue and segment sequencer. Depends on mke_pkg and all mke_ modules.
//
//  port group   dir  item                             accepted when
//  s_*          in   character [7:0]                  s_tvalid & s_tready
//  m_*          out  key_on [0], duration [19:1], last m_tvalid & m_tready
//  cfg_*        in   0 dot_length, 1 dash_dots        cfg_we
//
// The sequencer emits one segment per cycle while fed and not stalled: a letter or
// digit gives off/on segments per symbol plus a gap; a space one gap; others none.
// The front end takes one character per cycle while the 4-entry queue has room.
// arst_n clears the queue, sequencer and output valid; dot_length resets to 100
// and dash_dots to 3. A low m_tready with a segment waiting holds the output
// register and stalls the sequencer.
module morse_keying_encoder #(
	parameter int MAX_SYMBOLS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mke_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] character
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mke_pkg::M_TDATA_W-1:0]     m_tdata,   // [0] key_on, [19:1] duration
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [mke_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mke_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mke_pkg::*;

	logic [DOT_W-1:0]  dot_length_q;
	logic [DASH_W-1:0] dash_dots_q;
	logic              push;
	logic              pop;
	mke_item_t         wr_item;
	mke_item_t         rd_item;
	mke_qstat_t        qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_length_q <= DOT_LENGTH_RST;
			dash_dots_q  <= DASH_DOTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DOT_LENGTH: dot_length_q <= cfg_data[DOT_W-1:0];
				CFG_DASH_DOTS:  dash_dots_q  <= cfg_data[DASH_W-1:0];
				default:        dot_length_q <= dot_length_q;
			endcase
		end
	end

	mke_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.qstat    (qstat),
		.push     (push),
		.item     (wr_item)
	);

	mke_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	mke_back #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!qstat.empty),
		.head       (rd_item),
		.pop        (pop),
		.dot_length (dot_length_q),
		.dash_dots  (dash_dots_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
